// ----- src/asrs_pkg.sv -----
// Package for the adaptive silo rate switch: widths, register indexes,
// reset values and the type handed from cell to cell.
// No dependencies.
`default_nettype none

package asrs_pkg;

    localparam int UNITS   = 8;    // number of cells in the row (1 to 32)
    localparam int CNT_W   = 16;   // character count and smoothed rate width
    localparam int THR_W   = 16;   // threshold register width
    localparam int MASK_W  = 8;    // active mask and reported silo mask width
    localparam int UNIT_W  = 3;    // unit field width
    localparam int IDX_W   = 2;    // configuration index width
    localparam int SDATA_W = 8;    // input tdata width
    localparam int MDATA_W = 16;   // output tdata width

    // configuration register indexes
    localparam logic [IDX_W-1:0] CFG_HIGH   = 2'd0;
    localparam logic [IDX_W-1:0] CFG_LOW    = 2'd1;
    localparam logic [IDX_W-1:0] CFG_ACTIVE = 2'd2;

    // command codes carried in tuser
    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [THR_W-1:0]  HIGH_RESET = 16'd100;
    localparam logic [THR_W-1:0]  LOW_RESET  = 16'd75;
    localparam logic [MASK_W-1:0] ACTIVE_RESET = 8'd0;

    // running OR of silo bits along the row, before and after a tick
    typedef struct packed {
        logic any_before;
        logic any_after;
    } t_chain;

endpackage

`default_nettype wire

// ----- src/asrs_cell.sv -----
// One unit of the rate switch row: character count, smoothed rate, silo bit.
// Depends on asrs_pkg.
`default_nettype none

module asrs_cell (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_inc,
    input  wire logic                      i_tick,
    input  wire logic [asrs_pkg::THR_W-1:0] i_high,
    input  wire logic [asrs_pkg::THR_W-1:0] i_low,
    input  wire asrs_pkg::t_chain          i_chain,
    output asrs_pkg::t_chain               o_chain,
    output logic                           o_silo
);

    logic [asrs_pkg::CNT_W-1:0] r_count, n_count;
    logic [asrs_pkg::CNT_W-1:0] r_rate,  n_rate;
    logic                       r_en,    n_en;
    logic [asrs_pkg::CNT_W+3:0] w_sum;
    logic [asrs_pkg::CNT_W-1:0] w_rate_new;
    logic                       w_en_new;
    logic                       w_en_post;

    // 7*rate + count, then divide by 8
    assign w_sum      = {1'b0, r_rate, 3'b000} - {4'd0, r_rate} + {4'd0, r_count};
    assign w_rate_new = w_sum[asrs_pkg::CNT_W+2:3];

    always_comb begin
        if (r_count > i_high && !r_en) begin
            w_en_new = 1'b1;
        end else if (r_en && w_rate_new < i_low) begin
            w_en_new = 1'b0;
        end else begin
            w_en_new = r_en;
        end
    end

    always_comb begin
        n_count = r_count;
        n_rate  = r_rate;
        n_en    = r_en;
        if (i_tick) begin
            n_count = '0;
            n_rate  = w_rate_new;
            n_en    = w_en_new;
        end else if (i_inc && r_count != '1) begin
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_rate  <= '0;
            r_en    <= 1'b0;
        end else begin
            r_count <= n_count;
            r_rate  <= n_rate;
            r_en    <= n_en;
        end
    end

    // silo bit as it stands after this cycle's tick, if any
    assign w_en_post          = i_tick ? w_en_new : r_en;
    assign o_chain.any_before = i_chain.any_before | r_en;
    assign o_chain.any_after  = i_chain.any_after  | w_en_post;
    assign o_silo             = w_en_post;

    a_count_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tick |=> r_count == '0)
        else $error("count not cleared by tick");

    a_rise_needs_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_en) |-> $past(i_tick) && $past(r_count > i_high))
        else $error("silo enabled without count over high threshold");

    a_count_holds_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_tick && r_count == '1 |=> r_count == '1)
        else $error("count left its maximum without a tick");

endmodule

`default_nettype wire

// ----- src/adaptive_silo_rate_switch.sv -----
// Adaptive silo rate switch top level: stream ports, configuration registers,
// row of asrs_cell units and output register. Depends on asrs_pkg, asrs_cell.
//
// Use:
//   Input stream (i_s_*): one transaction per event. tuser[0] is the command:
//   0 counts a received character on the unit in tdata[2:0], 1 is the
//   once-per-second scan tick. A character transaction yields no output.
//   Output stream (o_m_*): one transaction per tick, carrying the silo mask
//   after the tick and the fast timer start flag (mask went empty to
//   non-empty).
//   Configuration channel (i_cfg_*): index 0 high threshold, 1 low threshold,
//   2 active mask; other indexes are dropped. Always ready; write only idle.
//   Throughput: one transaction per cycle unless stalled. Every unit is a cell
//   of the row and updates in the same cycle; the silo OR passes cell to cell.
//   Output: a tick result is on the output in the cycle after acceptance.
//   Stall: while an undelivered result sits in the output register and the
//   receiver holds tready low, o_s_tready drops and the input waits.
//   Reset (synchronous, active low): thresholds return to 100 and 75,
//   active mask, counts, rates, silo bits and the output valid flag clear.
`default_nettype none

module adaptive_silo_rate_switch (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input stream
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic [asrs_pkg::SDATA_W-1:0]  i_s_tdata,  // [2:0] unit
    input  wire logic [0:0]                    i_s_tuser,  // [0] cmd
    // output stream
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    output logic [asrs_pkg::MDATA_W-1:0]       o_m_tdata,  // [7:0] silo_mask, [8] fast_timer_start
    // configuration write channel
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [asrs_pkg::IDX_W-1:0]    i_cfg_index,
    input  wire logic [asrs_pkg::THR_W-1:0]    i_cfg_data
);

    localparam int U = asrs_pkg::UNITS;

    logic [asrs_pkg::THR_W-1:0]  r_high;
    logic [asrs_pkg::THR_W-1:0]  r_low;
    logic [asrs_pkg::MASK_W-1:0] r_active;

    logic                        r_out_valid;
    logic [asrs_pkg::MASK_W-1:0] r_out_mask;
    logic                        r_out_fts;

    logic                        w_s_fire;
    logic                        w_tick;
    logic                        w_char;
    logic [asrs_pkg::UNIT_W-1:0] w_unit;

    asrs_pkg::t_chain            w_chain [0:U];
    logic [U-1:0]                w_silo;
    logic [asrs_pkg::MASK_W-1:0] w_mask;
    logic [asrs_pkg::MASK_W-1:0] w_silo_low;

    // accept input whenever the output slot is free or is being drained
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_s_fire   = i_s_tvalid && o_s_tready;
    assign w_tick     = w_s_fire && (i_s_tuser[0] == asrs_pkg::CMD_TICK);
    assign w_char     = w_s_fire && (i_s_tuser[0] == asrs_pkg::CMD_CHAR);
    assign w_unit     = i_s_tdata[asrs_pkg::UNIT_W-1:0];

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high   <= asrs_pkg::HIGH_RESET;
            r_low    <= asrs_pkg::LOW_RESET;
            r_active <= asrs_pkg::ACTIVE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                asrs_pkg::CFG_HIGH:   r_high   <= i_cfg_data;
                asrs_pkg::CFG_LOW:    r_low    <= i_cfg_data;
                asrs_pkg::CFG_ACTIVE: r_active <= i_cfg_data[asrs_pkg::MASK_W-1:0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    // row of cells; the silo OR enters empty at the head of the row
    assign w_chain[0] = '0;

    for (genvar u = 0; u < U; u++) begin : g_cell
        logic w_inc;
        if (u < asrs_pkg::MASK_W) begin : g_act
            // only units covered by the active mask ever count
            assign w_inc = w_char && r_active[u] &&
                           (w_unit == asrs_pkg::UNIT_W'(u));
        end else begin : g_inact
            assign w_inc = 1'b0;
        end

        asrs_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_inc   (w_inc),
            .i_tick  (w_tick),
            .i_high  (r_high),
            .i_low   (r_low),
            .i_chain (w_chain[u]),
            .o_chain (w_chain[u+1]),
            .o_silo  (w_silo[u])
        );
    end

    // report only the low byte of the silo bits
    for (genvar b = 0; b < asrs_pkg::MASK_W; b++) begin : g_mask
        if (b < U) begin : g_on
            assign w_mask[b] = w_silo[b];
        end else begin : g_off
            assign w_mask[b] = 1'b0;
        end
    end

    assign w_silo_low = w_mask;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_tick) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tick) begin
            r_out_mask <= w_silo_low;
            r_out_fts  <= w_chain[U].any_after && !w_chain[U].any_before;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(asrs_pkg::MDATA_W - asrs_pkg::MASK_W - 1){1'b0}},
                         r_out_fts, r_out_mask};

    a_tick_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tick |=> o_m_tvalid)
        else $error("tick produced no result");

    a_char_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_char |=> !o_m_tvalid || $past(r_out_valid && !i_m_tready))
        else $error("character event produced a result");

    a_fts_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && r_out_fts |-> r_out_mask != '0)
        else $error("fast timer start with empty mask");

endmodule

`default_nettype wire

// ----- tb/tb_adaptive_silo_rate_switch.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for adaptive_silo_rate_switch: streams character and tick
// transactions, predicts each tick's silo mask and fast timer flag, and checks the results.
// Depends on asrs_pkg and the adaptive_silo_rate_switch RTL.

module tb_adaptive_silo_rate_switch;

    // index past the last register; a write there must change nothing
    localparam logic [asrs_pkg::IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int unsigned LIMIT = 400_000;   // cycles before the run is declared hung
    localparam int unsigned PHASES = 8;
    localparam int unsigned PHASE_ITEMS = 195;

    typedef struct packed {
        logic                          cmd;
        logic [asrs_pkg::UNIT_W-1:0]   unit;
    } t_line_event;

    typedef struct packed {
        logic [asrs_pkg::MASK_W-1:0] silo_mask;
        logic                        fast_timer_start;
    } t_silo_report;

    // DUT-facing signals; every input starts at a known value
    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_s_tvalid = 1'b0;
    logic                          o_s_tready;
    logic [asrs_pkg::SDATA_W-1:0]  i_s_tdata = '0;  // [2:0] unit, rest zero
    logic [0:0]                    i_s_tuser = '0;  // [0] cmd
    logic                          o_m_tvalid;
    logic                          i_m_tready = 1'b1;
    logic [asrs_pkg::MDATA_W-1:0]  o_m_tdata;       // [7:0] silo_mask, [8] fast_timer_start
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [asrs_pkg::IDX_W-1:0]    i_cfg_index = '0;
    logic [asrs_pkg::THR_W-1:0]    i_cfg_data = '0;

    // stimulus waiting for the driver, and tick reports waiting for the output
    t_line_event  line_events [$];
    t_silo_report silo_reports_due [$];

    // predictor state: per-unit tallies and rates, silo bits, register copies
    logic [asrs_pkg::CNT_W-1:0]  char_tally [asrs_pkg::UNITS];
    logic [asrs_pkg::CNT_W-1:0]  smoothed [asrs_pkg::UNITS];
    logic [asrs_pkg::UNITS-1:0]  silo_on = '0;
    logic [asrs_pkg::THR_W-1:0]  thr_high = asrs_pkg::HIGH_RESET;
    logic [asrs_pkg::THR_W-1:0]  thr_low = asrs_pkg::LOW_RESET;
    logic [asrs_pkg::MASK_W-1:0] unit_enable = asrs_pkg::ACTIVE_RESET;

    int unsigned idle_pct = 0;    // chance in 100 that the sender holds off
    int unsigned stall_pct = 0;   // chance in 100 that the receiver stalls
    bit          s_taken = 1'b0;  // input transaction at the last rising edge
    int unsigned cycle_count = 0;
    int unsigned error_count = 0;
    int unsigned events_in = 0;
    int unsigned ticks_in = 0;
    int unsigned reports_checked = 0;
    int unsigned reg_writes = 0;

    adaptive_silo_rate_switch i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Count a character on an enabled unit; hold the tally at its maximum.
    function automatic void note_character(logic [asrs_pkg::UNIT_W-1:0] u);
        if (unit_enable[u] && char_tally[u] != '1)
            char_tally[u] = char_tally[u] + 1'b1;
    endfunction

    // Close one second: blend the tally into the rate, apply the hysteresis,
    // clear the tally, and report the mask plus the empty to non-empty flag.
    function automatic t_silo_report advance_second();
        t_silo_report               rep;
        logic [asrs_pkg::UNITS-1:0] prior;
        int unsigned                blend;
        prior = silo_on;
        for (int u = 0; u < asrs_pkg::UNITS; u++) begin
            blend = (7 * int'(smoothed[u]) + int'(char_tally[u])) / 8;
            smoothed[u] = asrs_pkg::CNT_W'(blend);
            if (char_tally[u] > thr_high && !silo_on[u])
                silo_on[u] = 1'b1;
            else if (silo_on[u] && smoothed[u] < thr_low)
                silo_on[u] = 1'b0;
            char_tally[u] = '0;
        end
        rep.silo_mask = silo_on[asrs_pkg::MASK_W-1:0];
        rep.fast_timer_start = (prior == '0) && (silo_on != '0);
        return rep;
    endfunction

    // Hang guard: the run never gets close to this on a working block.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Monitor: sample every handshake at the rising edge, advance the predictor
    // on accepted transactions and check each delivered result against the oldest report due.
    always @(posedge i_clk) begin : watch_ports
        t_silo_report due;
        s_taken = i_rst_n && i_s_tvalid && o_s_tready;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                reg_writes++;
                case (i_cfg_index)
                    asrs_pkg::CFG_HIGH:   thr_high = i_cfg_data;
                    asrs_pkg::CFG_LOW:    thr_low = i_cfg_data;
                    asrs_pkg::CFG_ACTIVE: unit_enable = i_cfg_data[asrs_pkg::MASK_W-1:0];
                    default:    ;
                endcase
            end
            if (s_taken) begin
                events_in++;
                if (i_s_tuser[0] == asrs_pkg::CMD_TICK) begin
                    ticks_in++;
                    silo_reports_due.push_back(advance_second());
                end else begin
                    note_character(i_s_tdata[asrs_pkg::UNIT_W-1:0]);
                end
            end
            if (o_m_tvalid && i_m_tready) begin
                if (silo_reports_due.size() == 0) begin
                    $error("unexpected result: tdata %h with no tick pending", o_m_tdata);
                    error_count++;
                end else begin
                    due = silo_reports_due.pop_front();
                    reports_checked++;
                    if (o_m_tdata[asrs_pkg::MASK_W-1:0] !== due.silo_mask) begin
                        $error("silo_mask: expected %h, actual %h",
                               due.silo_mask, o_m_tdata[asrs_pkg::MASK_W-1:0]);
                        error_count++;
                    end
                    if (o_m_tdata[asrs_pkg::MASK_W] !== due.fast_timer_start) begin
                        $error("fast_timer_start: expected %b, actual %b",
                               due.fast_timer_start, o_m_tdata[asrs_pkg::MASK_W]);
                        error_count++;
                    end
                end
            end
        end
    end

    // Driver: change inputs at the falling edge only. Advance to the next
    // queued event once the current one is taken, or hold off at random.
    always @(negedge i_clk) begin : drive_ports
        t_line_event ev;
        i_m_tready <= ($urandom_range(99) >= stall_pct);
        if (i_rst_n && (!i_s_tvalid || s_taken)) begin
            if (line_events.size() != 0 && $urandom_range(99) >= idle_pct) begin
                ev = line_events.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tuser  <= ev.cmd;
                i_s_tdata  <= asrs_pkg::SDATA_W'(ev.unit);
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    task automatic post(logic cmd, logic [asrs_pkg::UNIT_W-1:0] unit);
        t_line_event ev;
        ev.cmd = cmd;
        ev.unit = unit;
        line_events.push_back(ev);
    endtask

    // Write one register and hold valid until the transaction completes.
    task automatic write_register(logic [asrs_pkg::IDX_W-1:0] idx,
                                  logic [asrs_pkg::THR_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Wait until every queued event is taken and every report has arrived,
    // then let a few cycles pass so a trailing character event finishes too.
    task automatic wait_idle();
        while (line_events.size() != 0 || i_s_tvalid || silo_reports_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Build seconds of traffic: a burst of characters, mostly on a few busy
    // units (enabled ones where any are), closed by a tick; sprinkle in lone random events as noise.
    // Mix heavy and light seconds at random so rates climb and decay.
    task automatic queue_random_seconds(int unsigned n_items,
                                        logic [asrs_pkg::MASK_W-1:0] enabled);
        int unsigned                 made;
        int unsigned                 burst;
        logic [asrs_pkg::MASK_W-1:0] busy;
        logic [asrs_pkg::UNIT_W-1:0] u;
        made = 0;
        while (made < n_items) begin
            if ($urandom_range(9) == 0) begin
                post(1'($urandom_range(1)), asrs_pkg::UNIT_W'($urandom_range(7)));
                made++;
            end else begin
                busy = asrs_pkg::MASK_W'($urandom_range(1, 255)) & enabled;
                if (busy == '0)
                    busy = asrs_pkg::MASK_W'($urandom_range(1, 255));
                burst = $urandom_range(1) ? $urandom_range(8, 30) : $urandom_range(0, 4);
                repeat (burst) begin
                    if ($urandom_range(3) != 0) begin
                        do u = asrs_pkg::UNIT_W'($urandom_range(7)); while (!busy[u]);
                    end else begin
                        u = asrs_pkg::UNIT_W'($urandom_range(7));
                    end
                    post(asrs_pkg::CMD_CHAR, u);
                end
                post(asrs_pkg::CMD_TICK, asrs_pkg::UNIT_W'($urandom_range(7)));
                made += burst + 1;
            end
        end
    endtask

    initial begin : run_test
        logic [asrs_pkg::THR_W-1:0] high_val;
        logic [asrs_pkg::THR_W-1:0] low_val;
        logic [asrs_pkg::THR_W-1:0] active_val;
        for (int u = 0; u < asrs_pkg::UNITS; u++) begin
            char_tally[u] = '0;
            smoothed[u] = '0;
        end
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Out of reset nothing is enabled: characters are dropped and ticks
        // report an empty mask.
        post(asrs_pkg::CMD_TICK, 3'd0);
        post(asrs_pkg::CMD_CHAR, 3'd0);
        post(asrs_pkg::CMD_CHAR, 3'd7);
        post(asrs_pkg::CMD_TICK, 3'd5);
        wait_idle();

        // Threshold extremes: a character on an enabled unit turns it on, and the very next
        // quiet second turns it off again. Upper data bits of the active mask and
        // the write to the unused index must be dropped.
        write_register(asrs_pkg::CFG_HIGH, 16'h0000);
        write_register(asrs_pkg::CFG_LOW, 16'hFFFF);
        write_register(asrs_pkg::CFG_ACTIVE, 16'hFFA5);
        write_register(CFG_UNUSED, 16'hFFFF);
        for (int u = 0; u < asrs_pkg::UNITS; u++)
            post(asrs_pkg::CMD_CHAR, asrs_pkg::UNIT_W'(u));
        post(asrs_pkg::CMD_TICK, 3'd0);
        post(asrs_pkg::CMD_TICK, 3'd7);
        wait_idle();

        // Random phases: rotate through the idling patterns and reconfigure
        // between phases, hitting both ends of each threshold along the way.
        for (int p = 0; p < PHASES; p++) begin
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 79; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 79; end
                default: begin idle_pct = 7; stall_pct = 7; end
            endcase
            case (p % 4)
                0: high_val = 16'h0000;
                1: high_val = 16'hFFFF;
                default: high_val = asrs_pkg::THR_W'($urandom_range(0, 15));
            endcase
            case (p % 4)
                1: low_val = 16'hFFFF;
                2: low_val = 16'h0000;
                default: low_val = asrs_pkg::THR_W'($urandom_range(0, 8));
            endcase
            active_val = (p % 3 == 0) ? 16'h00FF : asrs_pkg::THR_W'($urandom);
            write_register(asrs_pkg::CFG_HIGH, high_val);
            write_register(asrs_pkg::CFG_LOW, low_val);
            write_register(asrs_pkg::CFG_ACTIVE, active_val);
            write_register(CFG_UNUSED, asrs_pkg::THR_W'($urandom));
            queue_random_seconds(PHASE_ITEMS, active_val[asrs_pkg::MASK_W-1:0]);
            wait_idle();
        end

        $display("Run: %0d input transactions (%0d ticks), %0d results checked,",
                 events_in, ticks_in, reports_checked);
        $display("     %0d register writes over %0d random phases plus directed cases",
                 reg_writes, PHASES);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
